### sv/pbms_pkg.sv
`default_nettype none

package pbms_pkg;

  localparam int CMD_W     = 2;
  localparam int POS_W     = 3;
  localparam int LETTER_W  = 5;
  localparam int THR_W     = 17;
  localparam int FRAC_BITS = 16;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COUNT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GEN   = 2'd2;

  localparam logic [THR_W-1:0] FRAC_ONE = 17'd65536;

  typedef struct packed {
    logic load;
    logic clr_start;
    logic clr_step;
    logic cnt_wr;
    logic scan_start;
    logic scan_cum;
    logic mul;
    logic row_end;
    logic flush;
  } ctl_t;

  typedef struct packed {
    logic scan_busy;
    logic clr_last;
    logic row_last;
    logic cnt_ok;
    logic gen_ok;
  } stat_t;

endpackage

`default_nettype wire

### sv/pbms_ctrl.sv
`default_nettype none

module pbms_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [pbms_pkg::CMD_W-1:0]  cmd,
  input  wire pbms_pkg::stat_t             st,
  output pbms_pkg::ctl_t                   ctl,
  output logic                             busy
);

  localparam logic [3:0] S_CLR_GO  = 4'd0;
  localparam logic [3:0] S_CLR     = 4'd1;
  localparam logic [3:0] S_IDLE    = 4'd2;
  localparam logic [3:0] S_CNT_RD  = 4'd3;
  localparam logic [3:0] S_CNT_WR  = 4'd4;
  localparam logic [3:0] S_SUM_GO  = 4'd5;
  localparam logic [3:0] S_SUM     = 4'd6;
  localparam logic [3:0] S_MUL     = 4'd7;
  localparam logic [3:0] S_CUM_GO  = 4'd8;
  localparam logic [3:0] S_CUM     = 4'd9;
  localparam logic [3:0] S_ROW_END = 4'd10;
  localparam logic [3:0] S_FLUSH   = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR_GO;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    case (state)
      S_CLR_GO: begin
        ctl.clr_start = 1'b1;
        state_next = S_CLR;
      end
      S_CLR: begin
        ctl.clr_step = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          case (cmd)
            pbms_pkg::CMD_CLEAR: state_next = S_CLR_GO;
            pbms_pkg::CMD_COUNT: state_next = st.cnt_ok ? S_CNT_RD : S_IDLE;
            pbms_pkg::CMD_GEN:   state_next = st.gen_ok ? S_SUM_GO : S_IDLE;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_CNT_RD: begin
        state_next = S_CNT_WR;
      end
      S_CNT_WR: begin
        ctl.cnt_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_SUM_GO: begin
        ctl.scan_start = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        if (!st.scan_busy) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        ctl.mul = 1'b1;
        state_next = S_CUM_GO;
      end
      S_CUM_GO: begin
        ctl.scan_start = 1'b1;
        ctl.scan_cum = 1'b1;
        state_next = S_CUM;
      end
      S_CUM: begin
        if (!st.scan_busy) begin
          state_next = S_ROW_END;
        end
      end
      S_ROW_END: begin
        ctl.row_end = 1'b1;
        state_next = st.row_last ? S_FLUSH : S_SUM_GO;
      end
      S_FLUSH: begin
        ctl.flush = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

### sv/pbms_dpath.sv
`default_nettype none

module pbms_dpath #(
  parameter int ALPHABET   = 26,
  parameter int ROWS       = 5,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire pbms_pkg::ctl_t                 ctl,
  output pbms_pkg::stat_t                     st,
  input  wire logic [pbms_pkg::POS_W-1:0]     position,
  input  wire logic [pbms_pkg::LETTER_W-1:0]  from_letter,
  input  wire logic [pbms_pkg::LETTER_W-1:0]  to_letter,
  input  wire logic [pbms_pkg::LETTER_W-1:0]  first_letter,
  input  wire logic [pbms_pkg::THR_W-1:0]     threshold,
  output logic                                valid,
  output logic [pbms_pkg::LETTER_W-1:0]       letter,
  output logic                                last
);

  localparam int DEPTH = ROWS * ALPHABET * ALPHABET;
  localparam int AW    = $clog2(DEPTH);
  localparam int JW    = $clog2(ALPHABET);
  localparam int CW    = (JW > pbms_pkg::LETTER_W) ? JW : pbms_pkg::LETTER_W;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int TW    = COUNT_BITS + $clog2(ALPHABET);
  localparam int PW    = TW + pbms_pkg::THR_W;

  logic [COUNT_BITS-1:0]      mem [DEPTH];
  logic [COUNT_BITS-1:0]      rdata;
  logic [AW-1:0]              addr;
  logic                       we;
  logic [COUNT_BITS-1:0]      wdata;
  logic [COUNT_BITS-1:0]      sat_inc;

  logic [pbms_pkg::THR_W-1:0] thr;
  logic [CW-1:0]              cur;
  logic [CW-1:0]              pend;
  logic [RW-1:0]              row;

  logic                       iss;
  logic                       vld;
  logic                       mode_cum;
  logic [JW-1:0]              j;
  logic [JW-1:0]              jd;
  logic [TW-1:0]              total;
  logic [TW-1:0]              cum;
  logic [TW-1:0]              cum_new;
  logic [PW-1:0]              prod;
  logic                       found;
  logic [JW-1:0]              pick;
  logic                       hit;
  logic                       pick_ok;
  logic [CW-1:0]              pick_l;
  logic                       j_last;

  logic [AW-1:0]              cnt_addr;
  logic [AW-1:0]              row_base;

  assign cnt_addr = AW'((AW'(position) * AW'(ALPHABET) + AW'(from_letter)) * AW'(ALPHABET)
                        + AW'(to_letter));
  assign row_base = AW'((AW'(row) * AW'(ALPHABET) + AW'(cur)) * AW'(ALPHABET));

  assign st.cnt_ok    = (int'(position) < ROWS) && (int'(from_letter) < ALPHABET) &&
                        (int'(to_letter) < ALPHABET);
  assign st.gen_ok    = (int'(first_letter) < ALPHABET);
  assign st.clr_last  = (addr == AW'(DEPTH - 1));
  assign st.row_last  = (row == RW'(ROWS - 1));
  assign st.scan_busy = iss | vld;

  assign sat_inc = (rdata == '1) ? rdata : rdata + 1'b1;
  assign we      = ctl.clr_step | ctl.cnt_wr;
  assign wdata   = ctl.cnt_wr ? sat_inc : '0;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

  assign j_last = (j == JW'(ALPHABET - 1));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      addr <= cnt_addr;
    end else if (ctl.clr_start) begin
      addr <= '0;
    end else if (ctl.clr_step && !st.clr_last) begin
      addr <= addr + 1'b1;
    end else if (ctl.scan_start) begin
      addr <= row_base;
    end else if (iss && !j_last) begin
      addr <= addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss <= 1'b0;
      vld <= 1'b0;
    end else begin
      vld <= iss;
      if (ctl.scan_start) begin
        iss <= 1'b1;
      end else if (iss && j_last) begin
        iss <= 1'b0;
      end
    end
  end

  assign cum_new = cum + TW'(rdata);
  assign hit     = (PW'({cum_new, {pbms_pkg::FRAC_BITS{1'b0}}}) >= prod);

  always_ff @(posedge clk) begin
    jd <= j;
    if (ctl.scan_start) begin
      j        <= '0;
      mode_cum <= ctl.scan_cum;
      cum      <= '0;
      found    <= 1'b0;
      if (!ctl.scan_cum) begin
        total <= '0;
      end
    end else begin
      if (iss) begin
        j <= j + 1'b1;
      end
      if (vld) begin
        if (mode_cum) begin
          cum <= cum_new;
          if (hit && !found) begin
            found <= 1'b1;
            pick  <= jd;
          end
        end else begin
          total <= total + TW'(rdata);
        end
      end
    end
    if (ctl.mul) begin
      prod <= PW'(thr) * PW'(total);
    end
  end

  assign pick_ok = (total == '0) ? (thr == '0) : found;
  assign pick_l  = (total == '0) ? '0 : CW'(pick);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      thr  <= (threshold > pbms_pkg::FRAC_ONE) ? pbms_pkg::FRAC_ONE : threshold;
      cur  <= CW'(first_letter);
      pend <= CW'(first_letter);
      row  <= '0;
    end else if (ctl.row_end) begin
      row <= row + 1'b1;
      if (pick_ok) begin
        cur  <= pick_l;
        pend <= pick_l;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= (ctl.row_end && pick_ok) || ctl.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.row_end || ctl.flush) begin
      letter <= pend[pbms_pkg::LETTER_W-1:0];
      last   <= ctl.flush;
    end
  end

endmodule

`default_nettype wire

### sv/positional_bigram_markov_sampler.sv
`default_nettype none

// Channel    Handshake            Payload
// command    start / busy         cmd, position, from_letter, to_letter, first_letter, threshold
// result     valid (one cycle)    letter, last
//
// A transaction is taken on a clock edge with start high and busy low.
// Count is a read and a saturating write to the single-port count memory.
// Generate makes two passes per row over ALPHABET memory words, one word per cycle.
// Clear, and reset, sweep the count memory one word a cycle, all ROWS * ALPHABET * ALPHABET
// words, with busy high.
// Results come out one per valid cycle; the receiver cannot stall them.

module positional_bigram_markov_sampler #(
  parameter int ALPHABET   = 26,
  parameter int ROWS       = 5,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [pbms_pkg::CMD_W-1:0]     cmd,
  input  wire logic [pbms_pkg::POS_W-1:0]     position,
  input  wire logic [pbms_pkg::LETTER_W-1:0]  from_letter,
  input  wire logic [pbms_pkg::LETTER_W-1:0]  to_letter,
  input  wire logic [pbms_pkg::LETTER_W-1:0]  first_letter,
  input  wire logic [pbms_pkg::THR_W-1:0]     threshold,
  output logic                                valid,
  output logic [pbms_pkg::LETTER_W-1:0]       letter,
  output logic                                last
);

  pbms_pkg::ctl_t  ctl;
  pbms_pkg::stat_t st;

  pbms_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .st    (st),
    .ctl   (ctl),
    .busy  (busy)
  );

  pbms_dpath #(
    .ALPHABET   (ALPHABET),
    .ROWS       (ROWS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .st           (st),
    .position     (position),
    .from_letter  (from_letter),
    .to_letter    (to_letter),
    .first_letter (first_letter),
    .threshold    (threshold),
    .valid        (valid),
    .letter       (letter),
    .last         (last)
  );

  a_last_ends_word: assert property (@(posedge clk) disable iff (rst)
    valid && last |-> !busy)
    else $error("final letter shown while the generate transaction is still running");

  a_mid_word_busy: assert property (@(posedge clk) disable iff (rst)
    valid && !last |-> busy)
    else $error("inner letter shown after the generate transaction ended");

  a_scan_no_overlap: assert property (@(posedge clk) disable iff (rst)
    ctl.scan_start |-> !st.scan_busy)
    else $error("row scan restarted while the previous scan was still running");

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int ALPHABET = 26;
  localparam int ROWS = 5;
  localparam int COUNT_BITS = 16;
  localparam int unsigned COUNT_MAX = (1 << COUNT_BITS) - 1;
  localparam int RANDOM_ITEMS = 430;
  localparam int HEAVY_ITEMS = 20;
  localparam int WATCHDOG_LIMIT = 16000;
  localparam int TAIL_CYCLES = 400;
  localparam logic [pbms_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [pbms_pkg::LETTER_W-1:0] letter;
    logic                          last;
  } word_letter_t;

  class word_scoreboard;
    int unsigned pair_count [ROWS][ALPHABET][ALPHABET];
    word_letter_t expected_letters[$];
    int errors;
    int letters_checked;
    int words;

    function new();
      clear_counts();
      errors = 0;
      letters_checked = 0;
      words = 0;
    endfunction

    function void clear_counts();
      foreach (pair_count[r, f, t]) pair_count[r][f][t] = 0;
    endfunction

    function int pending();
      return expected_letters.size();
    endfunction

    // Roulette pick over one row: first letter whose running count reaches the threshold.
    function int next_letter(int row, int cur, longint unsigned thr);
      longint unsigned total;
      longint unsigned cum;
      total = 0;
      cum = 0;
      for (int j = 0; j < ALPHABET; j++) total += pair_count[row][cur][j];
      if (total == 0) return (thr == 0) ? 0 : -1;
      for (int j = 0; j < ALPHABET; j++) begin
        cum += pair_count[row][cur][j];
        if (cum * 65536 >= thr * total) return j;
      end
      return -1;
    endfunction

    function void note_command(logic [pbms_pkg::CMD_W-1:0] c,
                               logic [pbms_pkg::POS_W-1:0] pos,
                               logic [pbms_pkg::LETTER_W-1:0] from,
                               logic [pbms_pkg::LETTER_W-1:0] to,
                               logic [pbms_pkg::LETTER_W-1:0] first,
                               logic [pbms_pkg::THR_W-1:0] thr);
      word_letter_t word[$];
      word_letter_t item;
      longint unsigned thr_eff;
      int cur;
      int pick;
      case (c)
        pbms_pkg::CMD_CLEAR: clear_counts();
        pbms_pkg::CMD_COUNT: begin
          if (pos < ROWS && from < ALPHABET && to < ALPHABET &&
              pair_count[pos][from][to] < COUNT_MAX)
            pair_count[pos][from][to]++;
        end
        pbms_pkg::CMD_GEN: begin
          if (first < ALPHABET) begin
            thr_eff = (thr > pbms_pkg::FRAC_ONE) ? pbms_pkg::FRAC_ONE : thr;
            cur = first;
            item.letter = first;
            item.last = 1'b0;
            word.push_back(item);
            for (int row = 0; row < ROWS; row++) begin
              pick = next_letter(row, cur, thr_eff);
              if (pick >= 0) begin
                cur = pick;
                item.letter = pbms_pkg::LETTER_W'(pick);
                word.push_back(item);
              end
            end
            word[word.size() - 1].last = 1'b1;
            foreach (word[k]) expected_letters.push_back(word[k]);
            words++;
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("tb_top: mismatch: %s", msg);
      errors++;
    endtask

    task check_letter(logic [pbms_pkg::LETTER_W-1:0] got_letter, logic got_last);
      word_letter_t want;
      letters_checked++;
      if (expected_letters.size() == 0) begin
        report($sformatf("unexpected letter %0d last %0b", got_letter, got_last));
        return;
      end
      want = expected_letters.pop_front();
      if (got_letter !== want.letter)
        report($sformatf("letter %0d, wanted %0d", got_letter, want.letter));
      if (got_last !== want.last)
        report($sformatf("last %0b on letter %0d, wanted %0b", got_last, got_letter,
                         want.last));
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic [pbms_pkg::CMD_W-1:0]    cmd = pbms_pkg::CMD_CLEAR;
  logic [pbms_pkg::POS_W-1:0]    position = '0;
  logic [pbms_pkg::LETTER_W-1:0] from_letter = '0;
  logic [pbms_pkg::LETTER_W-1:0] to_letter = '0;
  logic [pbms_pkg::LETTER_W-1:0] first_letter = '0;
  logic [pbms_pkg::THR_W-1:0]    threshold = '0;
  logic                          busy;
  logic                          valid;
  logic [pbms_pkg::LETTER_W-1:0] letter;
  logic                          last;

  word_scoreboard sb;
  int idle_cycles = 0;
  int burst_left = 0;
  int commands_sent = 0;
  int clears_sent = 0;

  positional_bigram_markov_sampler #(
    .ALPHABET(ALPHABET),
    .ROWS(ROWS),
    .COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .position(position),
    .from_letter(from_letter),
    .to_letter(to_letter),
    .first_letter(first_letter),
    .threshold(threshold),
    .valid(valid),
    .letter(letter),
    .last(last)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && valid) sb.check_letter(letter, last);
  end

  always @(posedge clk) begin
    if ((start && !busy) || valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: watchdog expired with %0d letters outstanding", sb.pending());
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Every task below starts and ends just after a falling edge.
  task automatic send(input logic [pbms_pkg::CMD_W-1:0] c,
                      input logic [pbms_pkg::POS_W-1:0] pos,
                      input logic [pbms_pkg::LETTER_W-1:0] from,
                      input logic [pbms_pkg::LETTER_W-1:0] to,
                      input logic [pbms_pkg::LETTER_W-1:0] first,
                      input logic [pbms_pkg::THR_W-1:0] thr);
    cmd <= c;
    position <= pos;
    from_letter <= from;
    to_letter <= to;
    first_letter <= first;
    threshold <= thr;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_command(c, pos, from, to, first, thr);
    commands_sent++;
    if (c == pbms_pkg::CMD_CLEAR) clears_sent++;
    @(negedge clk);
  endtask

  task automatic send_count(input logic [pbms_pkg::POS_W-1:0] pos,
                            input logic [pbms_pkg::LETTER_W-1:0] from,
                            input logic [pbms_pkg::LETTER_W-1:0] to);
    send(pbms_pkg::CMD_COUNT, pos, from, to, pbms_pkg::LETTER_W'($urandom),
         pbms_pkg::THR_W'($urandom));
  endtask

  task automatic send_generate(input logic [pbms_pkg::LETTER_W-1:0] first,
                               input logic [pbms_pkg::THR_W-1:0] thr);
    send(pbms_pkg::CMD_GEN, pbms_pkg::POS_W'($urandom), pbms_pkg::LETTER_W'($urandom),
         pbms_pkg::LETTER_W'($urandom), first, thr);
  endtask

  task automatic send_clear();
    send(pbms_pkg::CMD_CLEAR, pbms_pkg::POS_W'($urandom), pbms_pkg::LETTER_W'($urandom),
         pbms_pkg::LETTER_W'($urandom), pbms_pkg::LETTER_W'($urandom),
         pbms_pkg::THR_W'($urandom));
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic sender_pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 12));
    end
    burst_left--;
  endtask

  // Letters are drawn mostly from a small set so that walks find populated rows.
  function automatic logic [pbms_pkg::LETTER_W-1:0] pick_letter();
    if ($urandom_range(0, 9) < 7) return pbms_pkg::LETTER_W'($urandom_range(0, 5));
    return pbms_pkg::LETTER_W'($urandom_range(0, ALPHABET - 1));
  endfunction

  function automatic logic [pbms_pkg::THR_W-1:0] pick_threshold();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return pbms_pkg::FRAC_ONE;
      2: return pbms_pkg::THR_W'($urandom_range(pbms_pkg::FRAC_ONE + 1,
                                                (1 << pbms_pkg::THR_W) - 1));
      3: return pbms_pkg::THR_W'($urandom_range(1, 255));
      default: return pbms_pkg::THR_W'($urandom_range(0, pbms_pkg::FRAC_ONE));
    endcase
  endfunction

  task automatic send_random_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 1) begin
      send_clear();
    end else if (sel < 56) begin
      send_count(pbms_pkg::POS_W'($urandom_range(0, ROWS - 1)), pick_letter(), pick_letter());
    end else if (sel < 88) begin
      send_generate(pick_letter(), pick_threshold());
    end else begin
      case ($urandom_range(0, 3))
        0: send_count(pbms_pkg::POS_W'($urandom_range(ROWS, 7)), pick_letter(), pick_letter());
        1: send_count(pbms_pkg::POS_W'($urandom_range(0, ROWS - 1)),
                      pbms_pkg::LETTER_W'($urandom_range(ALPHABET, 31)),
                      pbms_pkg::LETTER_W'($urandom));
        2: send(CMD_UNUSED, pbms_pkg::POS_W'($urandom), pbms_pkg::LETTER_W'($urandom),
                pbms_pkg::LETTER_W'($urandom), pbms_pkg::LETTER_W'($urandom),
                pbms_pkg::THR_W'($urandom));
        default: send_generate(pbms_pkg::LETTER_W'($urandom_range(ALPHABET, 31)),
                               pick_threshold());
      endcase
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_generate(5'd0, '0);
    send_generate(5'd25, 17'd1);
    send_generate(5'd26, '0);
    send_generate(5'd31, pbms_pkg::FRAC_ONE);
    send(CMD_UNUSED, 3'd7, 5'd31, 5'd31, 5'd31, 17'h1FFFF);
    send_count(3'd0, 5'd0, 5'd25);
    send_count(3'd0, 5'd0, 5'd3);
    send_count(3'd1, 5'd25, 5'd0);
    send_count(3'd1, 5'd3, 5'd25);
    send_count(3'd4, 5'd25, 5'd25);
    send_count(3'd5, 5'd0, 5'd1);
    send_count(3'd7, 5'd0, 5'd1);
    send_count(3'd0, 5'd26, 5'd1);
    send_count(3'd0, 5'd0, 5'd31);
    send_generate(5'd0, '0);
    send_generate(5'd0, pbms_pkg::FRAC_ONE);
    send_generate(5'd0, 17'h1FFFF);
    send_generate(5'd0, 17'd32768);
    send_generate(5'd25, 17'd65535);
    send_clear();
    send_generate(5'd0, '0);
    send_generate(5'd3, 17'd1);
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sender_pace();
      send_random_item();
      if ($urandom_range(0, 59) == 0) drain();
    end
    drain();

    // Load one pair heavily, then split the row with a second pair.
    for (int i = 0; i < HEAVY_ITEMS; i++) send_count(3'd3, 5'd12, 5'd20);
    send_count(3'd3, 5'd12, 5'd21);
    send_generate(5'd12, pbms_pkg::FRAC_ONE);
    send_generate(5'd12, 17'd1);
    send_generate(5'd12, 17'd65535);
    send_generate(5'd12, 17'h1FFFF);

    drain();
    while (busy) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d letters never arrived", sb.pending()));
    $display("tb_top: covered %0d commands (%0d clears, %0d words), %0d letters checked,",
             commands_sent, clears_sent, sb.words, sb.letters_checked);
    $display("tb_top: including empty rows, clamped thresholds, bad operands and a lopsided row");
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
